>>> hdl/jfps_pkg.sv
// Shared types and constants for the five-point stencil block.
// No dependencies; imported by the top level, jacobi_five_point_stencil_top.
package jfps_pkg;

  localparam int WidthBits  = 11;   // grid_width register and column counter
  localparam int HeightBits = 16;   // grid_height register and row counter
  localparam int ColOutBits = 10;   // reported column index
  localparam int CfgBits    = 16;   // widest configuration register
  localparam int MinSide    = 3;    // smallest grid side

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position and end mark that travel with each result transaction.
  typedef struct packed {
    logic [HeightBits-1:0] row;
    logic [ColOutBits-1:0] column;
    logic                  last_point;
  } point_pos_t;

endpackage

>>> hdl/jfps_line_store.sv
// Two line memories holding the two rows above the current one.
// Registered reads with bypass from the write in the same cycle.
// Depends on nothing outside this file.
module jfps_line_store #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [SAMPLE_BITS-1:0]       wr_sample,
  output logic [SAMPLE_BITS-1:0]       up_q,
  output logic [SAMPLE_BITS-1:0]       mid_q,
  output logic [SAMPLE_BITS-1:0]       right_q
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_WIDTH - 1);

  logic [SAMPLE_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [AW-1:0]          right_addr;

  // The right neighbor past the last entry is never used; wrap it.
  assign right_addr = (rd_addr == LastAddr) ? '0 : rd_addr + AW'(1);

  // Upper takes the middle value read for the item now in its write cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_q;
      middle_mem[wr_addr] <= wr_sample;
    end
    if (rd_en) begin
      up_q    <= (wr_en && wr_addr == rd_addr)    ? mid_q     : upper_mem[rd_addr];
      mid_q   <= (wr_en && wr_addr == rd_addr)    ? wr_sample : middle_mem[rd_addr];
      right_q <= (wr_en && wr_addr == right_addr) ? wr_sample : middle_mem[right_addr];
    end
  end

endmodule

>>> hdl/jfps_out_fifo.sv
// Three-entry result queue between the stencil datapath and the output channel.
// Depends on nothing outside this file.
module jfps_out_fifo #(
  parameter int DATA_BITS = 59
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output logic [DATA_BITS-1:0] head_data,
  output logic [1:0]           count
);

  localparam logic [1:0] LastSlot = 2'd2;

  logic [DATA_BITS-1:0] slot_r [3];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastSlot) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastSlot) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != 2'd0);
  assign head_data = slot_r[rd_ptr_r];
  assign count     = count_r;

endmodule

>>> hdl/jacobi_five_point_stencil_top.sv
// Top level of the streaming five-point Jacobi stencil.
// Uses jfps_pkg, jfps_line_store and jfps_out_fifo.

// Accepts one raster-order sample per clock cycle, sustained, for as long as the
// output side keeps up; the result for interior point (r-1, c) is formed in the write
// stage from the sample at (r, c) and then registered into the output queue. Each
// sample has a read, then a write, on both line memories; these overlap from sample to
// sample, which sets the rate of one per cycle. A three-entry output queue absorbs
// output stalls; input stalls once that queue and the item in flight would fill it.
// Border samples (rows 0 and 1, column 0, the last column) give no result.
// Configuration writes clamp grid_width to 3..MAX_WIDTH and grid_height to at least 3;
// write them only while no transaction is in flight.
module jacobi_five_point_stencil_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [jfps_pkg::CfgBits-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_average,
  output logic [jfps_pkg::HeightBits-1:0] out_row,
  output logic [jfps_pkg::ColOutBits-1:0] out_column,
  output logic                           out_last_point
);

  import jfps_pkg::*;

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int ResetW   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int PosBits  = $bits(point_pos_t);
  localparam int ItemBits = SAMPLE_BITS + PosBits;
  localparam int SumBits  = SAMPLE_BITS + 2;

  // Configuration
  logic [WidthBits-1:0]  grid_width_r;
  logic [HeightBits-1:0] grid_height_r;
  logic [WidthBits-1:0]  cfg_width;
  logic [HeightBits-1:0] cfg_height;

  always_comb begin
    cfg_width = cfg_data[WidthBits-1:0];
    if (cfg_width < WidthBits'(MinSide)) begin
      cfg_width = WidthBits'(MinSide);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      cfg_width = WidthBits'(MAX_WIDTH);
    end
    cfg_height = cfg_data[HeightBits-1:0];
    if (cfg_height < HeightBits'(MinSide)) begin
      cfg_height = HeightBits'(MinSide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= WidthBits'(ResetW);
      grid_height_r <= HeightBits'(MinSide);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width_r  <= cfg_width;
        REG_GRID_HEIGHT: grid_height_r <= cfg_height;
        default: ;
      endcase
    end
  end

  // Raster position of the incoming sample
  logic                  in_accept;
  logic [WidthBits-1:0]  col_r, col_nxt;
  logic [HeightBits-1:0] row_r, row_nxt;
  logic [WidthBits-1:0]  cur_col;
  logic [HeightBits:0]   cur_row_wide;
  logic [HeightBits-1:0] cur_row;
  logic [WidthBits:0]    col_plus2;
  logic [HeightBits:0]   row_plus1;
  logic                  cur_emit;
  logic                  cur_last;

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    // A column counter at or past the width starts the next row first.
    if (col_r >= grid_width_r) begin
      cur_col      = '0;
      cur_row_wide = {1'b0, row_r} + 1'b1;
    end else begin
      cur_col      = col_r;
      cur_row_wide = {1'b0, row_r};
    end
    cur_row = (cur_row_wide >= {1'b0, grid_height_r}) ? '0 : cur_row_wide[HeightBits-1:0];

    col_plus2 = {1'b0, cur_col} + (WidthBits+1)'(2);
    row_plus1 = {1'b0, cur_row} + 1'b1;
    cur_emit  = (cur_row >= HeightBits'(2)) && (cur_col != '0) &&
                (col_plus2 <= {1'b0, grid_width_r});
    cur_last  = (row_plus1 == {1'b0, grid_height_r}) &&
                (col_plus2 == {1'b0, grid_width_r});

    if ({1'b0, cur_col} + 1'b1 >= {1'b0, grid_width_r}) begin
      col_nxt = '0;
      row_nxt = (row_plus1 >= {1'b0, grid_height_r}) ? '0 : row_plus1[HeightBits-1:0];
    end else begin
      col_nxt = cur_col + 1'b1;
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Write stage: line memory data arrives, memories are updated, sum is formed
  logic                   s1_live_r;
  logic                   s1_emit_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [AW-1:0]          s1_addr_r;
  point_pos_t             s1_pos_r;
  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] up_q, mid_q, right_q;
  point_pos_t             cur_pos;

  always_comb begin
    cur_pos.row        = cur_row - 1'b1;
    cur_pos.column     = cur_col[ColOutBits-1:0];
    cur_pos.last_point = cur_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_live_r <= 1'b0;
      s1_emit_r <= 1'b0;
    end else begin
      s1_live_r <= in_accept;
      s1_emit_r <= in_accept && cur_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_addr_r   <= AW'(cur_col);
      s1_pos_r    <= cur_pos;
    end
  end

  // Left neighbor is the middle-line value read for the previous sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_live_r) begin
      left_r <= mid_q;
    end
  end

  jfps_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr   (AW'(cur_col)),
    .wr_en     (s1_live_r),
    .wr_addr   (s1_addr_r),
    .wr_sample (s1_sample_r),
    .up_q      (up_q),
    .mid_q     (mid_q),
    .right_q   (right_q)
  );

  logic signed [SumBits-1:0]     sum4;
  logic signed [SumBits-1:0]     quarter;
  logic [ItemBits-1:0]           push_item;
  logic [ItemBits-1:0]           head_item;
  logic [1:0]                    fifo_count;
  logic                          out_accept;

  // Exact four-term sum; arithmetic shift floors the quarter.
  assign sum4 = SumBits'($signed(up_q)) + SumBits'($signed(s1_sample_r)) +
                SumBits'($signed(left_r)) + SumBits'($signed(right_q));
  assign quarter   = sum4 >>> 2;
  assign push_item = {quarter[SAMPLE_BITS-1:0], s1_pos_r};

  jfps_out_fifo #(
    .DATA_BITS (ItemBits)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_emit_r),
    .push_data (push_item),
    .pop       (out_accept),
    .not_empty (out_valid),
    .head_data (head_item),
    .count     (fifo_count)
  );

  assign out_accept = out_valid && !out_stall;

  // Hold input when the queued results plus the one in flight could overflow the queue.
  assign in_stall = ({1'b0, fifo_count} + {2'b00, s1_emit_r}) >= 3'd3;

  point_pos_t head_pos;
  assign head_pos       = head_item[PosBits-1:0];
  assign out_average    = head_item[ItemBits-1:PosBits];
  assign out_row        = head_pos.row;
  assign out_column     = head_pos.column;
  assign out_last_point = head_pos.last_point;

endmodule
